>>> hw/rtl/urlb_pkg.sv
package urlb_pkg;

    localparam int unsigned TrigW    = 10;
    localparam int unsigned TickW    = 20;
    localparam int unsigned TpcW     = 12;
    localparam int unsigned DistW    = 15;
    localparam int unsigned ProdW    = DistW + TpcW;
    localparam int unsigned RemW     = 15;
    localparam int unsigned AddrW    = 5;
    localparam int unsigned DataW    = 32;
    localparam int unsigned RegIdxW  = 3;

    // width (us) to cm: floor(width * 343 / 20000)
    localparam logic [RemW-1:0] DistNum = RemW'(343);
    localparam logic [RemW-1:0] DistDen = RemW'(20000);

    localparam logic [TrigW-1:0] TrigTicksRst   = TrigW'(10);
    localparam logic [TickW-1:0] EchoTimeoutRst = TickW'(100000);
    localparam logic [TickW-1:0] LedMinRst      = TickW'(10000);
    localparam logic [TickW-1:0] LedMaxRst      = TickW'(1000000);
    localparam logic [TpcW-1:0]  LedTpcRst      = TpcW'(1000);

    typedef enum logic [RegIdxW-1:0] {
        REG_TRIG_TICKS   = 3'd0,
        REG_ECHO_TIMEOUT = 3'd1,
        REG_LED_MIN      = 3'd2,
        REG_LED_MAX      = 3'd3,
        REG_LED_TPC      = 3'd4
    } t_reg_idx;

    typedef struct packed {
        logic [TrigW-1:0] trigger_ticks;
        logic [TickW-1:0] echo_timeout_ticks;
        logic [TickW-1:0] led_min_ticks;
        logic [TickW-1:0] led_max_ticks;
        logic [TpcW-1:0]  led_ticks_per_cm;
    } t_cfg;

    typedef struct packed {
        logic             trigger_level;
        logic             led_level;
        logic             distance_valid;
        logic [DistW-1:0] distance_cm;
        logic             timed_out;
    } t_res;

    // one more tick completes a span of len ticks; zero acts as one
    function automatic logic span_done(input logic [TickW-1:0] count,
                                       input logic [TickW-1:0] len);
        return ({1'b0, count} + (TickW+1)'(1)) >= {1'b0, len};
    endfunction

endpackage

>>> hw/rtl/urlb_regs.sv
module urlb_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [urlb_pkg::AddrW-1:0]    paddr,
    input  logic [urlb_pkg::DataW-1:0]    pwdata,
    output logic [urlb_pkg::DataW-1:0]    prdata,
    output logic                          pready,
    output urlb_pkg::t_cfg                o_cfg
);

    urlb_pkg::t_cfg     r_cfg;
    urlb_pkg::t_reg_idx w_idx;
    logic               w_wr;

    assign pready = 1'b1;
    assign w_idx  = urlb_pkg::t_reg_idx'(paddr[urlb_pkg::AddrW-1:2]);
    assign w_wr   = psel && penable && pwrite;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.trigger_ticks      <= urlb_pkg::TrigTicksRst;
            r_cfg.echo_timeout_ticks <= urlb_pkg::EchoTimeoutRst;
            r_cfg.led_min_ticks      <= urlb_pkg::LedMinRst;
            r_cfg.led_max_ticks      <= urlb_pkg::LedMaxRst;
            r_cfg.led_ticks_per_cm   <= urlb_pkg::LedTpcRst;
        end else if (w_wr) begin
            unique case (w_idx)
                urlb_pkg::REG_TRIG_TICKS: begin
                    r_cfg.trigger_ticks <= pwdata[urlb_pkg::TrigW-1:0];
                end
                urlb_pkg::REG_ECHO_TIMEOUT: begin
                    r_cfg.echo_timeout_ticks <= pwdata[urlb_pkg::TickW-1:0];
                end
                urlb_pkg::REG_LED_MIN: begin
                    r_cfg.led_min_ticks <= pwdata[urlb_pkg::TickW-1:0];
                end
                urlb_pkg::REG_LED_MAX: begin
                    r_cfg.led_max_ticks <= pwdata[urlb_pkg::TickW-1:0];
                end
                urlb_pkg::REG_LED_TPC: begin
                    r_cfg.led_ticks_per_cm <= pwdata[urlb_pkg::TpcW-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            urlb_pkg::REG_TRIG_TICKS:   prdata = urlb_pkg::DataW'(r_cfg.trigger_ticks);
            urlb_pkg::REG_ECHO_TIMEOUT: prdata = urlb_pkg::DataW'(r_cfg.echo_timeout_ticks);
            urlb_pkg::REG_LED_MIN:      prdata = urlb_pkg::DataW'(r_cfg.led_min_ticks);
            urlb_pkg::REG_LED_MAX:      prdata = urlb_pkg::DataW'(r_cfg.led_max_ticks);
            urlb_pkg::REG_LED_TPC:      prdata = urlb_pkg::DataW'(r_cfg.led_ticks_per_cm);
            default:                    prdata = '0;
        endcase
    end

endmodule

>>> hw/rtl/urlb_core.sv
module urlb_core (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_step,
    input  logic                      i_echo,
    input  urlb_pkg::t_cfg            i_cfg,
    output urlb_pkg::t_res            o_res
);

    typedef enum logic [2:0] {
        PH_TRIGGER = 3'd0,
        PH_RISE    = 3'd1,
        PH_MEASURE = 3'd2,
        PH_LED_ON  = 3'd3,
        PH_LED_OFF = 3'd4
    } t_phase;

    t_phase                        r_phase,     n_phase;
    logic [urlb_pkg::TickW-1:0]    r_tick,      n_tick;
    logic [urlb_pkg::TickW-1:0]    r_half,      n_half;
    logic [urlb_pkg::DistW-1:0]    r_dist,      n_dist;
    logic [urlb_pkg::DistW-1:0]    r_quot,      n_quot;
    logic [urlb_pkg::RemW-1:0]     r_rem,       n_rem;

    logic [urlb_pkg::RemW-1:0]     w_rem_sum;
    logic                          w_wrap;
    logic [urlb_pkg::ProdW-1:0]    w_prod;
    logic [urlb_pkg::ProdW-1:0]    w_lo;
    logic [urlb_pkg::ProdW-1:0]    w_clamp;
    logic                          w_span_to;

    // running quotient/remainder of width*343/20000, one add a tick
    assign w_rem_sum = r_rem + urlb_pkg::DistNum;
    assign w_wrap    = w_rem_sum >= urlb_pkg::DistDen;
    assign w_prod    = urlb_pkg::ProdW'(r_quot) * urlb_pkg::ProdW'(i_cfg.led_ticks_per_cm);
    assign w_lo      = (w_prod < urlb_pkg::ProdW'(i_cfg.led_min_ticks))
                       ? urlb_pkg::ProdW'(i_cfg.led_min_ticks) : w_prod;
    assign w_clamp   = (w_lo > urlb_pkg::ProdW'(i_cfg.led_max_ticks))
                       ? urlb_pkg::ProdW'(i_cfg.led_max_ticks) : w_lo;
    assign w_span_to = urlb_pkg::span_done(r_tick, i_cfg.echo_timeout_ticks);

    always_comb begin
        n_phase = r_phase;
        n_tick  = r_tick;
        n_half  = r_half;
        n_dist  = r_dist;
        n_quot  = r_quot;
        n_rem   = r_rem;
        o_res   = '0;
        unique case (r_phase)
            PH_RISE: begin
                if (i_echo) begin
                    n_phase = PH_MEASURE;
                    n_tick  = urlb_pkg::TickW'(1);
                    n_quot  = '0;
                    n_rem   = urlb_pkg::DistNum;
                end else if (w_span_to) begin
                    o_res.timed_out = 1'b1;
                    n_phase = PH_TRIGGER;
                    n_tick  = '0;
                end else begin
                    n_tick = r_tick + urlb_pkg::TickW'(1);
                end
            end
            PH_MEASURE: begin
                if (i_echo) begin
                    if (w_span_to) begin
                        o_res.timed_out = 1'b1;
                        n_phase = PH_TRIGGER;
                        n_tick  = '0;
                    end else begin
                        n_tick = r_tick + urlb_pkg::TickW'(1);
                        if (w_wrap) begin
                            n_rem  = w_rem_sum - urlb_pkg::DistDen;
                            n_quot = r_quot + urlb_pkg::DistW'(1);
                        end else begin
                            n_rem = w_rem_sum;
                        end
                    end
                end else begin
                    o_res.distance_valid = 1'b1;
                    n_dist  = r_quot;
                    n_half  = w_clamp[urlb_pkg::TickW-1:0];
                    n_phase = PH_LED_ON;
                    n_tick  = '0;
                end
            end
            PH_LED_ON: begin
                o_res.led_level = 1'b1;
                if (urlb_pkg::span_done(r_tick, r_half)) begin
                    n_phase = PH_LED_OFF;
                    n_tick  = '0;
                end else begin
                    n_tick = r_tick + urlb_pkg::TickW'(1);
                end
            end
            PH_LED_OFF: begin
                if (urlb_pkg::span_done(r_tick, r_half)) begin
                    n_phase = PH_TRIGGER;
                    n_tick  = '0;
                end else begin
                    n_tick = r_tick + urlb_pkg::TickW'(1);
                end
            end
            default: begin
                o_res.trigger_level = 1'b1;
                if (urlb_pkg::span_done(r_tick, urlb_pkg::TickW'(i_cfg.trigger_ticks))) begin
                    n_phase = PH_RISE;
                    n_tick  = '0;
                end else begin
                    n_tick = r_tick + urlb_pkg::TickW'(1);
                end
            end
        endcase
        o_res.distance_cm = n_dist;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_TRIGGER;
            r_tick  <= '0;
            r_half  <= '0;
            r_dist  <= '0;
            r_quot  <= '0;
            r_rem   <= '0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_tick  <= n_tick;
            r_half  <= n_half;
            r_dist  <= n_dist;
            r_quot  <= n_quot;
            r_rem   <= n_rem;
        end
    end

    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_MEASURE |-> r_rem < urlb_pkg::DistDen)
        else $error("remainder out of range");

    a_quot_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_MEASURE |->
            (32'(r_quot) * 32'd20000 + 32'(r_rem)) == (32'(r_tick) * 32'd343))
        else $error("distance tracking lost step with width");

    a_fall_to_led: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && r_phase == PH_MEASURE && !i_echo |=>
            r_phase == PH_LED_ON && r_tick == '0 && r_dist == $past(r_quot))
        else $error("echo fall did not start LED phase");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_step |=> $stable(r_phase) && $stable(r_tick) && $stable(r_dist))
        else $error("state moved without a tick");

endmodule

>>> hw/rtl/ultrasonic_ranger_led_blinker.sv
// Ultrasonic ranger with distance-paced LED. Each input beat is one
// microsecond tick carrying the sampled echo level (s_axis_tdata[0]); each
// tick yields exactly one output beat with the trigger and LED pin levels,
// the last distance in cm and the timed_out / distance_valid flags. One beat
// is taken per clock whenever the output side accepts: the tick passes an
// input register, one pass of phase logic (a 15x12 multiply and clamp on
// the echo-fall tick) and an output register. Distance is
// floor(width*343/20000), tracked by a running remainder while echo is
// high. Registers sit on the APB port at byte addresses 0x00 trigger_ticks,
// 0x04 echo_timeout_ticks, 0x08 led_min_ticks, 0x0C led_max_ticks,
// 0x10 led_ticks_per_cm.
module ultrasonic_ranger_led_blinker (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    input  logic [7:0]                 s_axis_tdata,   // [0] echo_level
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    // [0] trigger_level, [1] led_level, [16:2] distance_cm, [17] timed_out
    output logic [23:0]                m_axis_tdata,
    output logic                       m_axis_tuser,   // [0] distance_valid
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [urlb_pkg::AddrW-1:0] paddr,
    input  logic [urlb_pkg::DataW-1:0] pwdata,
    output logic [urlb_pkg::DataW-1:0] prdata,
    output logic                       pready
);

    urlb_pkg::t_cfg w_cfg;
    urlb_pkg::t_res w_res;
    urlb_pkg::t_res r_out;
    logic           r_in_valid;
    logic           r_in_echo;
    logic           r_out_valid;
    logic           w_advance;
    logic           w_step;

    assign w_advance     = !r_out_valid || m_axis_tready;
    assign w_step        = r_in_valid && w_advance;
    assign s_axis_tready = !r_in_valid || w_advance;

    urlb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    urlb_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_step),
        .i_echo  (r_in_echo),
        .i_cfg   (w_cfg),
        .o_res   (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (w_advance) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_echo <= s_axis_tdata[0];
        end
        if (w_step) begin
            r_out <= w_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {6'b0, r_out.timed_out, r_out.distance_cm,
                            r_out.led_level, r_out.trigger_level};
    assign m_axis_tuser  = r_out.distance_valid;

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    localparam int NumRegs    = 5;
    localparam int MaxGap     = 11;
    localparam int Settle     = 4;
    localparam int CycleLimit = 2_000_000;
    localparam int RandItems  = 300;

    typedef enum logic [2:0] {
        PH_TRIG,
        PH_RISE,
        PH_MEAS,
        PH_LED_ON,
        PH_LED_OFF
    } t_phase;

    logic                         i_clk;
    logic                         i_rst_n       = 1'b0;
    logic                         s_axis_tvalid = 1'b0;
    logic                         s_axis_tready;
    logic [7:0]                   s_axis_tdata  = '0;   // [0] echo_level
    logic                         m_axis_tvalid;
    logic                         m_axis_tready = 1'b0;
    // [0] trigger_level, [1] led_level, [16:2] distance_cm, [17] timed_out
    logic [23:0]                  m_axis_tdata;
    logic                         m_axis_tuser;         // [0] distance_valid
    logic                         psel          = 1'b0;
    logic                         penable       = 1'b0;
    logic                         pwrite        = 1'b0;
    logic [urlb_pkg::AddrW-1:0]   paddr         = '0;
    logic [urlb_pkg::DataW-1:0]   pwdata        = '0;
    logic [urlb_pkg::DataW-1:0]   prdata;
    logic                         pready;

    ultrasonic_ranger_led_blinker u_top (.*);

    // ranger model state
    urlb_pkg::t_cfg               cfg;
    t_phase                       rng_phase;
    logic [urlb_pkg::TickW-1:0]   rng_count;
    logic [urlb_pkg::TickW-1:0]   led_half;
    logic [urlb_pkg::DistW-1:0]   last_cm;
    urlb_pkg::t_res               due_pins_q[$];

    int  errors       = 0;
    int  cycle_cnt    = 0;
    int  res_beats    = 0;
    int  random_items = 0;
    int  rise_wait    = 0;
    int  pulse_len    = 1;
    bit  tx_calm      = 1'b0;
    bit  rx_calm      = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt >= CycleLimit) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic logic span_end(input logic [urlb_pkg::TickW-1:0] cnt,
                                      input logic [urlb_pkg::TickW-1:0] len);
        return (21'(cnt) + 21'd1) >= 21'(len);
    endfunction

    function automatic urlb_pkg::t_res predict_tick(input logic echo);
        urlb_pkg::t_res r;
        logic [31:0]    half;
        r = '0;
        case (rng_phase)
            PH_RISE: begin
                if (echo) begin
                    rng_phase = PH_MEAS;
                    rng_count = urlb_pkg::TickW'(1);
                end else if (span_end(rng_count, cfg.echo_timeout_ticks)) begin
                    r.timed_out = 1'b1;
                    rng_phase   = PH_TRIG;
                    rng_count   = '0;
                end else begin
                    rng_count = rng_count + 1'b1;
                end
            end
            PH_MEAS: begin
                if (echo) begin
                    if (span_end(rng_count, cfg.echo_timeout_ticks)) begin
                        r.timed_out = 1'b1;
                        rng_phase   = PH_TRIG;
                        rng_count   = '0;
                    end else begin
                        rng_count = rng_count + 1'b1;
                    end
                end else begin
                    last_cm = urlb_pkg::DistW'((64'(rng_count) * 64'd343) / 64'd20000);
                    r.distance_valid = 1'b1;
                    half = 32'(last_cm) * 32'(cfg.led_ticks_per_cm);
                    if (half < 32'(cfg.led_min_ticks)) half = 32'(cfg.led_min_ticks);
                    if (half > 32'(cfg.led_max_ticks)) half = 32'(cfg.led_max_ticks);
                    led_half  = urlb_pkg::TickW'(half);
                    rng_phase = PH_LED_ON;
                    rng_count = '0;
                end
            end
            PH_LED_ON: begin
                r.led_level = 1'b1;
                if (span_end(rng_count, led_half)) begin
                    rng_phase = PH_LED_OFF;
                    rng_count = '0;
                end else begin
                    rng_count = rng_count + 1'b1;
                end
            end
            PH_LED_OFF: begin
                if (span_end(rng_count, led_half)) begin
                    rng_phase = PH_TRIG;
                    rng_count = '0;
                end else begin
                    rng_count = rng_count + 1'b1;
                end
            end
            default: begin
                r.trigger_level = 1'b1;
                if (span_end(rng_count, urlb_pkg::TickW'(cfg.trigger_ticks))) begin
                    rng_phase = PH_RISE;
                    rng_count = '0;
                end else begin
                    rng_count = rng_count + 1'b1;
                end
            end
        endcase
        r.distance_cm = last_cm;
        return r;
    endfunction

    // echo shaped around the predicted phase: a rise after rise_wait, a pulse of pulse_len
    function automatic logic next_echo();
        int   cap;
        logic e;
        cap = int'(cfg.echo_timeout_ticks) + 2;
        if (cap > 300) cap = 300;
        case (rng_phase)
            PH_RISE: e = (int'(rng_count) >= rise_wait);
            PH_MEAS: e = (int'(rng_count) < pulse_len);
            default: begin
                e = ($urandom_range(0, 19) == 0);
                if (rng_phase == PH_TRIG) begin
                    rise_wait = ($urandom_range(0, 4) != 0) ? $urandom_range(0, 8)
                                                            : $urandom_range(0, cap);
                    case ($urandom_range(0, 4))
                        0, 1:    pulse_len = $urandom_range(1, 5);
                        2, 3:    pulse_len = $urandom_range(55, 140);
                        default: pulse_len = $urandom_range(1, cap);
                    endcase
                end
            end
        endcase
        if ((rng_phase == PH_RISE || rng_phase == PH_MEAS) && $urandom_range(0, 29) == 0)
            e = !e;
        return e;
    endfunction

    task automatic report_mismatch(input string field, input int unsigned got,
                                   input int unsigned want);
        $display("mismatch on %s at beat %0d: got %0d, expected %0d",
                 field, res_beats, got, want);
        errors++;
    endtask

    task automatic send_tick(input logic echo);
        int gap;
        if ($urandom_range(0, 39) == 0) tx_calm = !tx_calm;
        gap = tx_calm ? 0 : $urandom_range(0, MaxGap);
        repeat (gap) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'b0, echo};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        due_pins_q.push_back(predict_tick(echo));
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (due_pins_q.size() != 0) @(posedge i_clk);
        repeat (Settle) @(posedge i_clk);
    endtask

    task automatic write_reg(input int idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= urlb_pkg::AddrW'(idx * 4);
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        case (idx)
            urlb_pkg::REG_TRIG_TICKS:
                cfg.trigger_ticks      = val[urlb_pkg::TrigW-1:0];
            urlb_pkg::REG_ECHO_TIMEOUT:
                cfg.echo_timeout_ticks = val[urlb_pkg::TickW-1:0];
            urlb_pkg::REG_LED_MIN:
                cfg.led_min_ticks      = val[urlb_pkg::TickW-1:0];
            urlb_pkg::REG_LED_MAX:
                cfg.led_max_ticks      = val[urlb_pkg::TickW-1:0];
            urlb_pkg::REG_LED_TPC:
                cfg.led_ticks_per_cm   = val[urlb_pkg::TpcW-1:0];
            default: ;
        endcase
    endtask

    task automatic configure(input logic [31:0] trig, input logic [31:0] tmo,
                             input logic [31:0] mn, input logic [31:0] mx,
                             input logic [31:0] tpc);
        drain_results();
        write_reg(urlb_pkg::REG_TRIG_TICKS, trig);
        write_reg(urlb_pkg::REG_ECHO_TIMEOUT, tmo);
        write_reg(urlb_pkg::REG_LED_MIN, mn);
        write_reg(urlb_pkg::REG_LED_MAX, mx);
        write_reg(urlb_pkg::REG_LED_TPC, tpc);
    endtask

    task automatic run_random(input int budget);
        int   sent;
        logic e;
        sent = 0;
        while (sent < budget) begin
            if ($urandom_range(0, 199) == 0) drain_results();
            if (rng_phase == PH_RISE || rng_phase == PH_MEAS) begin
                sent++;
            end
            random_items++;
            e = next_echo();
            send_tick(e);
        end
    endtask

    task automatic test_reset_values();
        for (int i = 0; i < 12; i++) send_tick(i % 3 == 0);
    endtask

    task automatic test_zero_registers();
        localparam logic [0:9] ZeroSeq = 10'b0011110000;
        configure(32'hFFFF_FC00, 32'hFFF0_0000, 32'h0, 32'h0, 32'h1);
        for (int i = 0; i < 10; i++) send_tick(ZeroSeq[i]);
    endtask

    task automatic test_clamp_and_masking();
        drain_results();
        for (int i = NumRegs; i < 8; i++) write_reg(i, $urandom);
        configure(32'hABCD_E402, 32'hFFF0_0050, 32'hFFFF_FFFF, 32'h00F0_0005, 32'hFFFF_F001);
        repeat (5) send_tick(1'b0);
        repeat (59) send_tick(1'b1);
        repeat (11) send_tick(1'b0);
    endtask

    task automatic test_random_extremes();
        configure(32'd1023, 32'd1048575, 32'd1, 32'd1048575, 32'd1);
        run_random(10);
        configure(32'd1, 32'd1, 32'd1, 32'd3, 32'd4095);
        run_random(40);
        configure(32'd2, 32'd120, 32'd0, 32'd40, 32'd4095);
        run_random(60);
    endtask

    task automatic test_random_mixed();
        logic [31:0] tmo;
        int          start;
        start = random_items;
        while (random_items - start < RandItems) begin
            tmo = ($urandom_range(0, 9) < 7) ? $urandom_range(40, 250) : $urandom_range(0, 3);
            configure($urandom_range(0, 6) | ($urandom << urlb_pkg::TrigW),
                      tmo | ($urandom << urlb_pkg::TickW),
                      $urandom_range(0, 30) | ($urandom << urlb_pkg::TickW),
                      $urandom_range(0, 60) | ($urandom << urlb_pkg::TickW),
                      $urandom);
            run_random(40);
        end
    endtask

    initial begin
        int gap;
        gap = 0;
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            if (m_axis_tvalid && m_axis_tready) begin
                if ($urandom_range(0, 39) == 0) rx_calm = !rx_calm;
                gap = rx_calm ? 0 : $urandom_range(0, MaxGap);
            end
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                gap--;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    urlb_pkg::t_res got_r;
    urlb_pkg::t_res want_r;

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got_r.trigger_level  = m_axis_tdata[0];
            got_r.led_level      = m_axis_tdata[1];
            got_r.distance_cm    = m_axis_tdata[16:2];
            got_r.timed_out      = m_axis_tdata[17];
            got_r.distance_valid = m_axis_tuser;
            if (due_pins_q.size() == 0) begin
                report_mismatch("unexpected beat", 1, 0);
            end else begin
                want_r = due_pins_q.pop_front();
                if (got_r.trigger_level !== want_r.trigger_level)
                    report_mismatch("trigger_level", got_r.trigger_level, want_r.trigger_level);
                if (got_r.led_level !== want_r.led_level)
                    report_mismatch("led_level", got_r.led_level, want_r.led_level);
                if (got_r.distance_valid !== want_r.distance_valid)
                    report_mismatch("distance_valid", got_r.distance_valid,
                                    want_r.distance_valid);
                if (got_r.distance_cm !== want_r.distance_cm)
                    report_mismatch("distance_cm", got_r.distance_cm, want_r.distance_cm);
                if (got_r.timed_out !== want_r.timed_out)
                    report_mismatch("timed_out", got_r.timed_out, want_r.timed_out);
            end
            res_beats++;
        end
    end

    initial begin
        cfg       = '{urlb_pkg::TrigTicksRst, urlb_pkg::EchoTimeoutRst, urlb_pkg::LedMinRst,
                      urlb_pkg::LedMaxRst, urlb_pkg::LedTpcRst};
        rng_phase = PH_TRIG;
        rng_count = '0;
        led_half  = '0;
        last_cm   = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_values();
        test_zero_registers();
        test_clamp_and_masking();
        test_random_extremes();
        test_random_mixed();

        drain_results();
        repeat (8) @(posedge i_clk);
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
